// ===== hdl/skle_pkg.sv =====
// Shared types, constants and helpers for the SSH KEXINIT list extractor.
// No dependencies; used by the top level.
package skle_pkg;

   // Header bytes ahead of the first name list
   localparam int unsigned HEADER_SKIP = 22;
   // Bytes in one big-endian length prefix
   localparam int unsigned PREFIX_BYTES = 4;
   localparam int unsigned PREFIX_CNT_W = $clog2(PREFIX_BYTES);
   // Eight name lists, indexed 0..7
   localparam int unsigned LIST_IDX_W = 3;
   localparam logic [LIST_IDX_W-1:0] LIST_KEX      = 3'd0;
   localparam logic [LIST_IDX_W-1:0] LIST_HOSTKEY  = 3'd1;
   localparam logic [LIST_IDX_W-1:0] LIST_COMP_C2S = 3'd6;
   localparam logic [LIST_IDX_W-1:0] LIST_LAST     = 3'd7;
   // Separator character ';'
   localparam logic [7:0] SEMICOLON = 8'd59;
   // Result slots needed for the worst single input byte
   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned RES_CNT_W = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_SEP     = 2'd1,
      KIND_SUMMARY = 2'd2
   } result_kind_type;

   typedef struct packed {
      result_kind_type result_kind;
      logic [7:0]      out_byte;
      logic [15:0]     hash_length;
      logic            packet_valid;
      logic            end_of_packet;
   } rsp_entry_type;

   // Kex list always copied, host-key list never; pairs pick by side
   function automatic logic list_copied(input logic [LIST_IDX_W-1:0] idx,
                                        input logic side);
      logic copied;
      if (idx == LIST_KEX) begin
         copied = 1'b1;
      end else if (idx == LIST_HOSTKEY) begin
         copied = 1'b0;
      end else if (idx[0] == 1'b0) begin
         copied = side;
      end else begin
         copied = ~side;
      end
      return copied;
   endfunction

endpackage

// ===== hdl/skle_req_if.sv =====
// Input channel: one payload byte per transaction with packet context.
// Valid/ready handshake; no package dependency.
interface skle_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [15:0] payload_length;
   logic        client_side;
   logic        last_byte;

   modport source (output valid, data_byte, payload_length, client_side, last_byte,
                   input ready);
   modport sink   (input valid, data_byte, payload_length, client_side, last_byte,
                   output ready);
endinterface

// ===== hdl/skle_rsp_if.sv =====
// Result channel: copied bytes, separators and the end-of-packet summary.
// Valid/ready handshake; no package dependency.
interface skle_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  out_byte;
   logic [15:0] hash_length;
   logic        packet_valid;
   logic        end_of_packet;

   modport source (output valid, result_kind, out_byte, hash_length, packet_valid,
                   end_of_packet, input ready);
   modport sink   (input valid, result_kind, out_byte, hash_length, packet_valid,
                   end_of_packet, output ready);
endinterface

// ===== hdl/ssh_kexinit_list_extractor.sv =====
// Channel   | Dir | Transaction
// ----------+-----+---------------------------------------------------------
// req_ch    | in  | one KEXINIT payload byte, packet length, side, last flag
// rsp_ch    | out | copied list byte, ';' separator, or end-of-packet summary
//
// One byte is parsed in the cycle it is accepted; its results appear on rsp_ch
// from the next cycle. A byte giving two or three results holds req_ch.ready low
// while the three-entry result register drains, one entry per cycle while
// rsp_ch.ready is high; a stall on rsp_ch holds req_ch.ready low as well.
// Synchronous active-high reset clears the parser state and empties the result
// register. Depends on skle_pkg, skle_req_if and skle_rsp_if.
module ssh_kexinit_list_extractor #(
   parameter int unsigned HEADER_SKIP = skle_pkg::HEADER_SKIP
) (
   input logic         clock,
   input logic         reset,
   skle_req_if.sink    req_ch,
   skle_rsp_if.source  rsp_ch
);

   localparam int unsigned LW = skle_pkg::LIST_IDX_W;
   localparam int unsigned PW = skle_pkg::PREFIX_CNT_W;
   localparam int unsigned CW = skle_pkg::RES_CNT_W;

   // Parser state
   logic [15:0]   pos_ff, pos_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic          body_ff, body_in;
   logic [PW-1:0] pcnt_ff, pcnt_in;
   logic [31:0]   acc_ff, acc_in;
   logic [31:0]   rem_ff, rem_in;
   logic [15:0]   emit_ff, emit_in;
   logic          err_ff, err_in;
   logic          done_ff, done_in;

   // Result register
   skle_pkg::rsp_entry_type slot_ff [skle_pkg::MAX_RESULTS];
   skle_pkg::rsp_entry_type slot_in [skle_pkg::MAX_RESULTS];
   logic [CW-1:0] cnt_ff, cnt_in;

   skle_pkg::rsp_entry_type res [skle_pkg::MAX_RESULTS];
   logic [CW-1:0] res_cnt;

   logic        req_take, rsp_take;
   logic        active, copy, finish, emit_byte, emit_sep, sum_valid;
   logic [16:0] pos_p4, pos_p1, emit_sum;
   logic [17:0] fit_sum;
   logic [31:0] rem_dec;

   assign req_take = req_ch.valid & req_ch.ready;
   assign rsp_take = rsp_ch.valid & rsp_ch.ready;

   // Accept when the result register empties by the end of this cycle
   assign req_ch.ready = (cnt_ff == '0) || ((cnt_ff == CW'(1)) && rsp_ch.ready);

   // Low half of the completed prefix plus body start plus one
   assign pos_p4  = {1'b0, pos_ff} + 17'd4;
   assign pos_p1  = {1'b0, pos_ff} + 17'd1;
   assign fit_sum = {2'b00, acc_ff[7:0], req_ch.data_byte} + {2'b00, pos_ff} + 18'd2;
   assign rem_dec = rem_ff - 32'd1;

   // Parse one byte
   always_comb begin
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      body_in   = body_ff;
      pcnt_in   = pcnt_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      err_in    = err_ff;
      done_in   = done_ff;
      finish    = 1'b0;
      emit_byte = 1'b0;
      emit_sep  = 1'b0;
      active    = !done_ff && !err_ff && (pos_ff >= 16'(HEADER_SKIP));
      copy      = skle_pkg::list_copied(idx_ff, req_ch.client_side);

      if (active) begin
         if (!body_ff) begin
            if ((pcnt_ff == '0) && (pos_p4 >= {1'b0, req_ch.payload_length})) begin
               err_in = 1'b1;
            end else begin
               acc_in  = {acc_ff[23:0], req_ch.data_byte};
               pcnt_in = pcnt_ff + PW'(1);
               if (pcnt_ff == PW'(skle_pkg::PREFIX_BYTES - 1)) begin
                  if (copy && ((pos_p1 >= {1'b0, req_ch.payload_length}) ||
                               (acc_in[31:16] != '0) ||
                               (fit_sum >= {2'b00, req_ch.payload_length}))) begin
                     err_in = 1'b1;
                  end else if ((idx_ff == skle_pkg::LIST_LAST) && !copy) begin
                     done_in = 1'b1;
                  end else if (acc_in == '0) begin
                     finish = 1'b1;
                  end else begin
                     body_in = 1'b1;
                     rem_in  = acc_in;
                  end
               end
            end
         end else begin
            emit_byte = copy;
            rem_in    = rem_dec;
            finish    = (rem_dec == '0);
         end
      end

      // Close the current list
      if (finish) begin
         emit_sep = copy && (idx_ff < skle_pkg::LIST_COMP_C2S);
         body_in  = 1'b0;
         if (idx_ff == skle_pkg::LIST_LAST) begin
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + LW'(1);
         end
      end

      // Saturating counters
      emit_sum = {1'b0, emit_ff} + {16'd0, emit_byte} + {16'd0, emit_sep};
      emit_in  = emit_sum[16] ? 16'hFFFF : emit_sum[15:0];
      if (pos_ff != 16'hFFFF) begin
         pos_in = pos_ff + 16'd1;
      end

      // Build the results in order
      for (int i = 0; i < skle_pkg::MAX_RESULTS; i++) begin
         res[i] = '{result_kind: skle_pkg::KIND_BYTE, out_byte: 8'd0,
                    hash_length: 16'd0, packet_valid: 1'b0, end_of_packet: 1'b0};
      end
      res_cnt = '0;
      if (emit_byte) begin
         res[0].out_byte = req_ch.data_byte;
         res_cnt = CW'(1);
      end
      if (emit_sep) begin
         res[res_cnt[1:0]].result_kind = skle_pkg::KIND_SEP;
         res[res_cnt[1:0]].out_byte    = skle_pkg::SEMICOLON;
         res_cnt = res_cnt + CW'(1);
      end
      sum_valid = !err_in && done_in;
      if (req_ch.last_byte) begin
         res[res_cnt[1:0]].result_kind   = skle_pkg::KIND_SUMMARY;
         res[res_cnt[1:0]].hash_length   = sum_valid ? emit_in : 16'd0;
         res[res_cnt[1:0]].packet_valid  = sum_valid;
         res[res_cnt[1:0]].end_of_packet = 1'b1;
         res_cnt = res_cnt + CW'(1);
         // Clear for the next packet
         pos_in  = '0;
         idx_in  = '0;
         body_in = 1'b0;
         pcnt_in = '0;
         acc_in  = '0;
         rem_in  = '0;
         emit_in = '0;
         err_in  = 1'b0;
         done_in = 1'b0;
      end
   end

   // Load or shift the result register
   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (req_take) begin
         slot_in = res;
         cnt_in  = res_cnt;
      end else if (rsp_take) begin
         for (int i = 0; i < skle_pkg::MAX_RESULTS - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
         cnt_in = cnt_ff - CW'(1);
      end
   end

   // Advance parser state on each accepted transaction; update the result count
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         idx_ff  <= '0;
         body_ff <= 1'b0;
         pcnt_ff <= '0;
         acc_ff  <= '0;
         rem_ff  <= '0;
         emit_ff <= '0;
         err_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (req_take) begin
            pos_ff  <= pos_in;
            idx_ff  <= idx_in;
            body_ff <= body_in;
            pcnt_ff <= pcnt_in;
            acc_ff  <= acc_in;
            rem_ff  <= rem_in;
            emit_ff <= emit_in;
            err_ff  <= err_in;
            done_ff <= done_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // Drive the head entry
   assign rsp_ch.valid         = (cnt_ff != '0);
   assign rsp_ch.result_kind   = slot_ff[0].result_kind;
   assign rsp_ch.out_byte      = slot_ff[0].out_byte;
   assign rsp_ch.hash_length   = slot_ff[0].hash_length;
   assign rsp_ch.packet_valid  = slot_ff[0].packet_valid;
   assign rsp_ch.end_of_packet = slot_ff[0].end_of_packet;

endmodule

// ===== hdl/skle_checker.sv =====
// Port-level checks for ssh_kexinit_list_extractor, with the bind that attaches them.
// No package dependency; the bind connects to the top level's channel interfaces.
module skle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_result_kind,
   input logic [7:0]  rsp_out_byte,
   input logic [15:0] rsp_hash_length,
   input logic        rsp_packet_valid,
   input logic        rsp_end_of_packet
);

   // Every packet end yields a pending summary in the next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> rsp_valid)
      else $error("no result after last byte transaction");

   // Input stalls only while results are pending
   a_stall_has_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty result register");

   // An invalid packet reports zero length
   a_invalid_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_packet && !rsp_packet_valid |-> rsp_hash_length == 16'd0)
      else $error("invalid packet with nonzero hash length");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) &&
         $stable(rsp_out_byte) && $stable(rsp_hash_length) &&
         $stable(rsp_packet_valid) && $stable(rsp_end_of_packet))
      else $error("stalled result transaction changed");

endmodule

bind ssh_kexinit_list_extractor skle_checker u_skle_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_last_byte     (req_ch.last_byte),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_result_kind   (rsp_ch.result_kind),
   .rsp_out_byte      (rsp_ch.out_byte),
   .rsp_hash_length   (rsp_ch.hash_length),
   .rsp_packet_valid  (rsp_ch.packet_valid),
   .rsp_end_of_packet (rsp_ch.end_of_packet)
);
